/* rtl/urxf_pkg.sv */
// urxf_pkg: shared types and constants of the serial port register block
// with receive FIFO. No dependencies.
`default_nettype none

package urxf_pkg;

    // item kinds
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_RX    = 2'd2,
        FUNC_BREAK = 2'd3
    } func_t;

    // register byte offsets
    localparam logic [5:0] OFF_MODE       = 6'h00;
    localparam logic [5:0] OFF_BAUD       = 6'h04;
    localparam logic [5:0] OFF_CONTROL    = 6'h08;
    localparam logic [5:0] OFF_TX_DATA    = 6'h0c;
    localparam logic [5:0] OFF_STATUS     = 6'h10;
    localparam logic [5:0] OFF_RX_DATA    = 6'h14;
    localparam logic [5:0] OFF_FIFO_CTRL  = 6'h18;
    localparam logic [5:0] OFF_FIFO_COUNT = 6'h1c;
    localparam logic [5:0] OFF_PORT       = 6'h20;
    localparam logic [5:0] OFF_LINE_STAT  = 6'h24;

    // write masks
    localparam logic [7:0] MODE_MASK_FIFO    = 8'h7b;
    localparam logic [7:0] CONTROL_MASK_FIFO = 8'hfa;
    localparam logic [7:0] PORT_MASK_FIFO    = 8'hf3;
    localparam logic [7:0] PORT_MASK_PLAIN   = 8'h8f;
    localparam logic [7:0] MASK_ALL          = 8'hff;

    // reset values
    localparam logic [7:0] BAUD_RESET    = 8'hff;
    localparam logic [7:0] CONTROL_RESET = 8'h20;

    // control register bits
    localparam int CTL_TX_IRQ_EN = 7;
    localparam int CTL_RX_IRQ_EN = 6;
    localparam int CTL_TX_EN     = 5;
    localparam int CTL_RX_EN     = 4;

    // status flag bits (internal order)
    localparam int FLG_TEND = 0;
    localparam int FLG_TDE  = 1;
    localparam int FLG_RDF  = 2;
    localparam int FLG_BRK  = 3;
    localparam int FLG_DR   = 4;
    localparam logic [4:0] FLAGS_RESET = 5'b00011;

    // status register bits as seen on the bus
    localparam int SR_TEND = 6;
    localparam int SR_TDE  = 5;
    localparam int SR_BRK  = 4;
    localparam int SR_RDF  = 1;
    localparam int SR_DR   = 0;

    // fifo control bits
    localparam int FCR_CLEAR = 1;

    // trigger levels
    localparam logic [3:0] TRIG_1  = 4'd1;
    localparam logic [3:0] TRIG_4  = 4'd4;
    localparam logic [3:0] TRIG_8  = 4'd8;
    localparam logic [3:0] TRIG_14 = 4'd14;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } urxf_cmd_t;

endpackage

`default_nettype wire

/* rtl/urxf_if.sv */
// urxf channel interfaces: item input, result output and configuration write.
// Depends on nothing.
`default_nettype none

interface urxf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [5:0]  reg_offset;
    logic [15:0] write_data;
    logic [7:0]  rx_byte;

    modport source (output valid, func, reg_offset, write_data, rx_byte, input ready);
    modport sink (input valid, func, reg_offset, write_data, rx_byte, output ready);
endinterface

interface urxf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        access_error;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_irq;
    logic        tx_irq;
    logic        rx_dropped;

    modport source (output valid, read_data, access_error, tx_valid, tx_byte, rx_irq,
                    tx_irq, rx_dropped, input ready);
    modport sink (input valid, read_data, access_error, tx_valid, tx_byte, rx_irq,
                  tx_irq, rx_dropped, output ready);
endinterface

interface urxf_cfg_if;
    logic valid;
    logic ready;
    logic fifo_mode;

    modport source (output valid, fifo_mode, input ready);
    modport sink (input valid, fifo_mode, output ready);
endinterface

`default_nettype wire

/* rtl/urxf_ctrl.sv */
// urxf_ctrl: handshake controller, sequences one item through capture,
// execute and result hold. Depends on urxf_pkg.
`default_nettype none

module urxf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output urxf_pkg::urxf_cmd_t    cmd
);
    import urxf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HOLD
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    // state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= ST_EXEC;
                        in_ready_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    state_reg     <= ST_HOLD;
                    out_valid_reg <= 1'b1;
                end
                ST_HOLD:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    in_ready_reg  <= 1'b1;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // commands to the datapath
    assign cmd.capture = in_valid & in_ready_reg;
    assign cmd.execute = (state_reg == ST_EXEC);

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/urxf_datapath.sv */
// urxf_datapath: register file, status flags, receive FIFO memory and the
// per-item update logic. Depends on urxf_pkg.
`default_nettype none

module urxf_datapath #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire urxf_pkg::urxf_cmd_t cmd,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_fifo_mode,
    input  wire logic [1:0]          func,
    input  wire logic [5:0]          reg_offset,
    input  wire logic [15:0]         write_data,
    input  wire logic [7:0]          rx_byte,
    output logic [15:0]              read_data,
    output logic                     access_error,
    output logic                     tx_valid,
    output logic [7:0]               tx_byte,
    output logic                     rx_irq,
    output logic                     tx_irq,
    output logic                     rx_dropped
);
    import urxf_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);

    // captured item
    func_t       func_reg;
    logic [5:0]  offset_reg;
    logic [7:0]  wbyte_reg;
    logic [7:0]  rx_byte_reg;

    // architectural state
    logic          fifo_mode_reg;
    logic [7:0]    mode_reg, mode_next;
    logic [7:0]    baud_reg, baud_next;
    logic [7:0]    control_reg, control_next;
    logic [7:0]    port_reg, port_next;
    logic [4:0]    flags_reg, flags_next;
    logic [3:0]    trigger_reg, trigger_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic          rx_irq_reg, rx_irq_next;
    logic          tx_irq_reg, tx_irq_next;

    // fifo memory
    logic [7:0]    mem [FIFO_DEPTH];
    logic [7:0]    mem_rdata_reg;
    logic          mem_we;

    // result
    logic [15:0]   rd_reg, rd_next;
    logic          err_reg, err_next;
    logic          txv_reg, txv_next;
    logic [7:0]    txb_reg, txb_next;
    logic          drop_reg, drop_next;

    // item capture on input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= func_t'(func);
            offset_reg  <= reg_offset;
            wbyte_reg   <= write_data[7:0];
            rx_byte_reg <= rx_byte;
        end
    end

    // fifo write port and registered read at the read pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wptr_reg] <= rx_byte_reg;
        end
        mem_rdata_reg <= mem[rptr_reg];
    end

    // per-item update
    always_comb
    begin
        mode_next    = mode_reg;
        baud_next    = baud_reg;
        control_next = control_reg;
        port_next    = port_reg;
        flags_next   = flags_reg;
        trigger_next = trigger_reg;
        count_next   = count_reg;
        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        rx_irq_next  = rx_irq_reg;
        tx_irq_next  = tx_irq_reg;
        mem_we       = 1'b0;
        rd_next      = 16'd0;
        err_next     = 1'b0;
        txv_next     = 1'b0;
        txb_next     = 8'd0;
        drop_next    = 1'b0;

        case (func_reg)
            FUNC_WRITE:
            begin
                case (offset_reg)
                    OFF_MODE:
                        mode_next = wbyte_reg & (fifo_mode_reg ? MODE_MASK_FIFO : MASK_ALL);
                    OFF_BAUD:
                        baud_next = wbyte_reg;
                    OFF_CONTROL:
                    begin
                        control_next = wbyte_reg
                                     & (fifo_mode_reg ? CONTROL_MASK_FIFO : MASK_ALL);
                        if (!wbyte_reg[CTL_TX_EN])
                            flags_next[FLG_TEND] = 1'b1;
                        if (fifo_mode_reg)
                            tx_irq_next = wbyte_reg[CTL_TX_IRQ_EN];
                        if (!wbyte_reg[CTL_RX_IRQ_EN])
                            rx_irq_next = 1'b0;
                    end
                    OFF_TX_DATA:
                    begin
                        txv_next = 1'b1;
                        txb_next = wbyte_reg;
                        flags_next[FLG_TDE] = 1'b0;
                    end
                    OFF_STATUS:
                    begin
                        if (fifo_mode_reg)
                        begin
                            // flags written as zero clear
                            if (!wbyte_reg[SR_TEND]) flags_next[FLG_TEND] = 1'b0;
                            if (!wbyte_reg[SR_TDE])  flags_next[FLG_TDE]  = 1'b0;
                            if (!wbyte_reg[SR_BRK])  flags_next[FLG_BRK]  = 1'b0;
                            if (!wbyte_reg[SR_RDF])  flags_next[FLG_RDF]  = 1'b0;
                            if (!wbyte_reg[SR_DR])   flags_next[FLG_DR]   = 1'b0;
                            if (!wbyte_reg[SR_RDF] || !wbyte_reg[SR_DR])
                                rx_irq_next = 1'b0;
                        end
                        else
                            err_next = 1'b1;
                    end
                    OFF_FIFO_CTRL:
                    begin
                        if (fifo_mode_reg)
                        begin
                            case (wbyte_reg[7:6])
                                2'd0:    trigger_next = TRIG_1;
                                2'd1:    trigger_next = TRIG_4;
                                2'd2:    trigger_next = TRIG_8;
                                default: trigger_next = TRIG_14;
                            endcase
                            if (wbyte_reg[FCR_CLEAR])
                            begin
                                count_next = '0;
                                wptr_next  = '0;
                                rptr_next  = '0;
                            end
                        end
                        else
                            err_next = 1'b1;
                    end
                    OFF_PORT:
                    begin
                        if (fifo_mode_reg)
                            port_next = wbyte_reg & PORT_MASK_FIFO;
                        else
                            err_next = 1'b1;
                    end
                    OFF_LINE_STAT:
                        err_next = !fifo_mode_reg;
                    OFF_FIFO_COUNT:
                    begin
                        // plain map puts the port register here
                        if (fifo_mode_reg)
                            err_next = 1'b1;
                        else
                            port_next = wbyte_reg & PORT_MASK_PLAIN;
                    end
                    default:
                        err_next = 1'b1;
                endcase
            end
            FUNC_READ:
            begin
                if (!fifo_mode_reg)
                begin
                    if (offset_reg == OFF_FIFO_COUNT)
                        rd_next = {8'd0, port_reg};
                    else
                        err_next = 1'b1;
                end
                else
                begin
                    case (offset_reg)
                        OFF_MODE:
                            rd_next = {8'd0, mode_reg};
                        OFF_CONTROL:
                            rd_next = {8'd0, control_reg};
                        OFF_STATUS:
                        begin
                            rd_next[SR_TEND] = flags_reg[FLG_TEND];
                            rd_next[SR_TDE]  = flags_reg[FLG_TDE];
                            rd_next[SR_BRK]  = flags_reg[FLG_BRK];
                            rd_next[SR_RDF]  = flags_reg[FLG_RDF];
                            rd_next[SR_DR]   = flags_reg[FLG_DR];
                            if (control_reg[CTL_TX_EN])
                            begin
                                flags_next[FLG_TDE]  = 1'b1;
                                flags_next[FLG_TEND] = 1'b1;
                            end
                        end
                        OFF_RX_DATA:
                        begin
                            if (count_reg == '0)
                                err_next = 1'b1;
                            else
                            begin
                                rd_next    = {8'd0, mem_rdata_reg};
                                rptr_next  = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                if (count_next < CW'(trigger_reg))
                                    flags_next[FLG_RDF] = 1'b0;
                            end
                        end
                        OFF_FIFO_COUNT:
                            rd_next = 16'(count_reg);
                        OFF_PORT:
                            rd_next = {8'd0, port_reg};
                        OFF_LINE_STAT:
                            rd_next = 16'd0;
                        default:
                            err_next = 1'b1;
                    endcase
                end
            end
            FUNC_RX:
            begin
                if (!control_reg[CTL_RX_EN] || !fifo_mode_reg || count_reg >= FULL_COUNT)
                    drop_next = 1'b1;
                else
                begin
                    mem_we     = 1'b1;
                    wptr_next  = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    if (count_next >= CW'(trigger_reg))
                    begin
                        flags_next[FLG_RDF] = 1'b1;
                        if (control_reg[CTL_RX_IRQ_EN])
                            rx_irq_next = 1'b1;
                    end
                end
            end
            FUNC_BREAK:
            begin
                if (fifo_mode_reg)
                    flags_next[FLG_BRK] = 1'b1;
            end
            default:
            begin
                err_next = 1'b0;
            end
        endcase

        // only commit during the execute cycle
        if (!cmd.execute)
            mem_we = 1'b0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_mode_reg <= 1'b1;
            mode_reg      <= 8'd0;
            baud_reg      <= BAUD_RESET;
            control_reg   <= CONTROL_RESET;
            port_reg      <= 8'd0;
            flags_reg     <= FLAGS_RESET;
            trigger_reg   <= TRIG_1;
            count_reg     <= '0;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            rx_irq_reg    <= 1'b0;
            tx_irq_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                fifo_mode_reg <= cfg_fifo_mode;
            if (cmd.execute)
            begin
                mode_reg    <= mode_next;
                baud_reg    <= baud_next;
                control_reg <= control_next;
                port_reg    <= port_next;
                flags_reg   <= flags_next;
                trigger_reg <= trigger_next;
                count_reg   <= count_next;
                wptr_reg    <= wptr_next;
                rptr_reg    <= rptr_next;
                rx_irq_reg  <= rx_irq_next;
                tx_irq_reg  <= tx_irq_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            rd_reg   <= rd_next;
            err_reg  <= err_next;
            txv_reg  <= txv_next;
            txb_reg  <= txb_next;
            drop_reg <= drop_next;
        end
    end

    assign read_data    = rd_reg;
    assign access_error = err_reg;
    assign tx_valid     = txv_reg;
    assign tx_byte      = txb_reg;
    assign rx_irq       = rx_irq_reg;
    assign tx_irq       = tx_irq_reg;
    assign rx_dropped   = drop_reg;

endmodule

`default_nettype wire

/* rtl/uart_registers_with_rx_fifo.sv */
// uart_registers_with_rx_fifo: top level of the serial port register block.
// Depends on urxf_pkg, urxf_if, urxf_ctrl and urxf_datapath.
//
//   channel  | dir  | moves per transfer
//   ---------+------+----------------------------------------------------------
//   in_ch    | in   | func, reg_offset, write_data, rx_byte
//   out_ch   | out  | read_data, access_error, tx_valid, tx_byte, rx_irq, tx_irq,
//            |      | rx_dropped
//   cfg_ch   | in   | fifo_mode (always ready)
//
// One item at a time: a new one is taken only once the last result has been
// transferred; each item goes from input transfer to execute, then to hold,
// where the result is held until its transfer, at whose edge ready returns. The
// receive FIFO memory is read at the read pointer on the capture edge, so its
// data is ready for execute. Reset restores state, but not item or result,
// registers to power-on values; FIFO memory is not cleared and needs no clearing pass.
`default_nettype none

module uart_registers_with_rx_fifo #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    urxf_in_if.sink    in_ch,
    urxf_out_if.source out_ch,
    urxf_cfg_if.sink   cfg_ch
);
    import urxf_pkg::*;

    urxf_cmd_t cmd;

    // configuration writes are always taken
    assign cfg_ch.ready = 1'b1;

    // handshake sequencing
    urxf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // registers, flags and receive FIFO
    urxf_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_valid     (cfg_ch.valid),
        .cfg_fifo_mode (cfg_ch.fifo_mode),
        .func          (in_ch.func),
        .reg_offset    (in_ch.reg_offset),
        .write_data    (in_ch.write_data),
        .rx_byte       (in_ch.rx_byte),
        .read_data     (out_ch.read_data),
        .access_error  (out_ch.access_error),
        .tx_valid      (out_ch.tx_valid),
        .tx_byte       (out_ch.tx_byte),
        .rx_irq        (out_ch.rx_irq),
        .tx_irq        (out_ch.tx_irq),
        .rx_dropped    (out_ch.rx_dropped)
    );

endmodule

`default_nettype wire
